[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority thread scheduler with sleep.
// ----------------------------------------------------------------------------
package pts_pkg;

    // table size; slot 0 is the idle thread
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // field widths of the request and response
    localparam int KEY_W  = 16;
    localparam int DUR_W  = 31;
    localparam int TIME_W = 32;
    localparam int SEL_W  = 4;

    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot IDLE_SLOT  = t_slot'(0);
    localparam t_slot FIRST_SLOT = t_slot'(1);
    localparam t_slot LAST_SLOT  = t_slot'(SLOT_COUNT - 1);

    // request commands
    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_SLEEP    = 2'd1,
        CMD_YIELD    = 2'd2,
        CMD_EXIT     = 2'd3
    } t_cmd;

    // status of one slot
    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_SLEEP = 2'd2,
        SLOT_EXIT  = 2'd3
    } t_slot_status;

    // one word of the slot table
    typedef struct packed {
        t_slot_status        status;
        logic [KEY_W-1:0]    key;
        logic [TIME_W-1:0]   wake;
    } t_slot_entry;

    // read port request
    typedef struct packed {
        logic  en;
        t_slot addr;
    } t_mem_rd;

    // write port request
    typedef struct packed {
        logic        en;
        t_slot       addr;
        t_slot_entry data;
    } t_mem_wr;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_SCAN,
        S_CUR_RD,
        S_SCH_START,
        S_SCH_SCAN,
        S_DONE
    } t_fsm_state;

endpackage

[rtl/pts_if.sv]
// ----------------------------------------------------------------------------
// pts_if
// Request and response channels of the scheduler, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pts_req_if import pts_pkg::*; ();
    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [KEY_W-1:0]    thread_key;
    logic [DUR_W-1:0]    duration_ms;
    logic [TIME_W-1:0]   now_ms;

    modport source (
        output valid, command, thread_key, duration_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, thread_key, duration_ms, now_ms,
        output ready
    );
endinterface

interface pts_rsp_if import pts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEL_W-1:0]    selected_slot;
    logic                table_full;

    modport source (
        output valid, selected_slot, table_full,
        input  ready
    );
    modport sink (
        input  valid, selected_slot, table_full,
        output ready
    );
endinterface

[rtl/pts_slot_mem.sv]
// ----------------------------------------------------------------------------
// pts_slot_mem
// Slot table: one-read one-write memory with registered read data and a
// valid flag per slot so that an unwritten slot reads as empty.
// ----------------------------------------------------------------------------
module pts_slot_mem import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_rd     i_rd,
    input  t_mem_wr     i_wr,
    output t_slot_entry o_rd_data
);

    t_slot_entry             r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   r_valid;
    t_slot_entry             r_rd_data;
    logic                    r_rd_valid;

    // per-slot valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= r_mem[i_rd.addr];
            r_rd_valid <= r_valid[i_rd.addr];
        end
    end

    // a never-written slot reads as empty
    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.status = SLOT_EMPTY;
        end
    end

endmodule

[rtl/pts_ctrl.sv]
// ----------------------------------------------------------------------------
// pts_ctrl
// Command sequencer: slot search, running-slot update and priority scan
// over the slot table, one slot per cycle, plus the response register.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pts_req_if.sink      i_req,
    pts_rsp_if.source    o_rsp,
    output t_mem_rd      o_rd,
    output t_mem_wr      o_wr,
    input  t_slot_entry  i_rd_data
);

    t_fsm_state         r_state, n_state;
    t_slot              r_running, n_running;
    t_slot              r_idx, n_idx;
    t_slot              r_sel, n_sel;
    logic               r_full, n_full;
    logic               r_out_valid, n_out_valid;
    logic               out_load;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [DUR_W-1:0]   r_dur;
    logic [TIME_W-1:0]  r_now;
    logic [SEL_W-1:0]   r_out_sel;
    logic               r_out_full;

    logic               accept;
    logic               last;
    logic               woken;
    t_slot              idx_next;

    assign accept   = i_req.valid && i_req.ready;
    assign last     = (r_idx == LAST_SLOT);
    assign idx_next = r_idx + FIRST_SLOT;
    assign woken    = (i_rd_data.status == SLOT_SLEEP) && (i_rd_data.wake < r_now);

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.selected_slot = r_out_sel;
    assign o_rsp.table_full    = r_out_full;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= IDLE_SLOT;
            r_idx       <= IDLE_SLOT;
            r_sel       <= IDLE_SLOT;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_idx       <= n_idx;
            r_sel       <= n_sel;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    // request capture and response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.command;
            r_key <= i_req.thread_key;
            r_dur <= i_req.duration_ms;
            r_now <= i_req.now_ms;
        end
        if (out_load) begin
            r_out_sel  <= SEL_W'(r_sel);
            r_out_full <= r_full;
        end
    end

    // next state, table accesses and response handoff
    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_idx       = r_idx;
        n_sel       = r_sel;
        n_full      = r_full;
        n_out_valid = r_out_valid && !o_rsp.ready;
        out_load    = 1'b0;
        o_rd        = '0;
        o_wr        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_full = 1'b0;
                    n_sel  = IDLE_SLOT;
                    n_idx  = FIRST_SLOT;
                    unique case (i_req.command)
                        CMD_REGISTER: begin
                            o_rd    = '{en: 1'b1, addr: FIRST_SLOT};
                            n_state = S_REG_SCAN;
                        end
                        CMD_SLEEP, CMD_EXIT: begin
                            if (r_running != IDLE_SLOT) begin
                                o_rd    = '{en: 1'b1, addr: r_running};
                                n_state = S_CUR_RD;
                            end else begin
                                o_rd    = '{en: 1'b1, addr: FIRST_SLOT};
                                n_state = S_SCH_SCAN;
                            end
                        end
                        CMD_YIELD: begin
                            o_rd    = '{en: 1'b1, addr: FIRST_SLOT};
                            n_state = S_SCH_SCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // search for a matching key or the first empty slot
            S_REG_SCAN: begin
                if (i_rd_data.status == SLOT_EMPTY || i_rd_data.key == r_key) begin
                    o_wr.en          = 1'b1;
                    o_wr.addr        = r_idx;
                    o_wr.data.status = SLOT_READY;
                    o_wr.data.key    = r_key;
                    o_wr.data.wake   = i_rd_data.wake;
                    n_sel            = r_idx;
                    n_state          = S_DONE;
                end else if (last) begin
                    n_full  = 1'b1;
                    n_sel   = IDLE_SLOT;
                    n_state = S_DONE;
                end else begin
                    o_rd  = '{en: 1'b1, addr: idx_next};
                    n_idx = idx_next;
                end
            end

            // running slot goes to sleep or exits
            S_CUR_RD: begin
                o_wr.addr = r_running;
                o_wr.data = i_rd_data;
                if (r_cmd == CMD_SLEEP) begin
                    o_wr.en          = (i_rd_data.status != SLOT_EMPTY);
                    o_wr.data.status = SLOT_SLEEP;
                    o_wr.data.wake   = r_now + TIME_W'(r_dur);
                end else begin
                    o_wr.en          = 1'b1;
                    o_wr.data.status = SLOT_EXIT;
                end
                n_state = S_SCH_START;
            end

            S_SCH_START: begin
                o_rd    = '{en: 1'b1, addr: FIRST_SLOT};
                n_idx   = FIRST_SLOT;
                n_state = S_SCH_SCAN;
            end

            // priority scan, waking expired sleepers on the way
            S_SCH_SCAN: begin
                if (i_rd_data.status == SLOT_EMPTY) begin
                    n_sel     = IDLE_SLOT;
                    n_running = IDLE_SLOT;
                    n_state   = S_DONE;
                end else if (woken || i_rd_data.status == SLOT_READY) begin
                    o_wr.en          = woken;
                    o_wr.addr        = r_idx;
                    o_wr.data        = i_rd_data;
                    o_wr.data.status = SLOT_READY;
                    n_sel            = r_idx;
                    n_running        = r_idx;
                    n_state          = S_DONE;
                end else if (last) begin
                    n_sel     = IDLE_SLOT;
                    n_running = IDLE_SLOT;
                    n_state   = S_DONE;
                end else begin
                    o_rd  = '{en: 1'b1, addr: idx_next};
                    n_idx = idx_next;
                end
            end

            // hand the result to the response register once it is free
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/priority_thread_scheduler_with_sleep_unit.sv]
// ----------------------------------------------------------------------------
// priority_thread_scheduler_with_sleep_unit
// Fixed-priority thread slot scheduler with timed sleep.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: command (register, sleep, yield, exit),
//   thread_key, duration_ms and now_ms. o_rsp returns one response per
//   request: selected_slot (registered slot or slot to run next) and
//   table_full. Both channels use valid/ready.
//   A request is accepted, then the slot table is walked one slot per
//   cycle through its single registered read port. Register searches k
//   slots (up to 15); yield scans the same way; sleep and exit of a
//   running thread add a read-modify-write of that slot ahead of the scan.
//   One request is in flight at a time; the next one is accepted while the
//   previous response still waits in the output register.
//   Reset clears all slots to empty (per-slot valid flags) and sets the
//   running slot to idle; no clearing pass is needed.
//   When the receiver stalls, the response holds and at most one further
//   request completes its work before the request side stops.
// ----------------------------------------------------------------------------
module priority_thread_scheduler_with_sleep_unit import pts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_req_if.sink    i_req,
    pts_rsp_if.source  o_rsp
);

    t_mem_rd      rd;
    t_mem_wr      wr;
    t_slot_entry  rd_data;

    // command sequencer
    pts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd      (rd),
        .o_wr      (wr),
        .i_rd_data (rd_data)
    );

    // slot table
    pts_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

endmodule

[rtl/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  logic [SEL_W-1:0]  i_rsp_sel,
    input  logic              i_rsp_full
);

    // a pending response stays until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // a full table always reports the idle slot
    a_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_full |-> i_rsp_sel == '0)
        else $error("table full with nonzero slot");

    // one request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // reset leaves no response pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind priority_thread_scheduler_with_sleep_unit pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_sel   (o_rsp.selected_slot),
    .i_rsp_full  (o_rsp.table_full)
);

[test/pts_sched_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_sched_checker
// Watches the request and response channels of the scheduler, keeps its own
// copy of the slot table to work out each expected answer, and compares every
// response field by field in request order.
// ----------------------------------------------------------------------------
module pts_sched_checker import pts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pts_req_if   i_req,
    pts_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen
);

    typedef struct packed {
        logic [SEL_W-1:0] slot;
        logic             full;
    } t_answer;

    // shadow slot table
    t_slot_status      slot_state [SLOT_COUNT];
    logic [KEY_W-1:0]  slot_key   [SLOT_COUNT];
    logic [TIME_W-1:0] wake_at    [SLOT_COUNT];
    t_slot             running;

    t_answer answer_q [$];
    t_answer want;
    int      mismatch_count = 0;
    int      checked_count  = 0;
    int      full_count     = 0;

    assign o_errors    = mismatch_count;
    assign o_checked   = checked_count;
    assign o_full_seen = full_count;

    // fixed-priority pick, waking overdue sleepers on the way
    function automatic logic [SEL_W-1:0] run_next(input logic [TIME_W-1:0] now);
        int s;
        int pick;
        bit scanning;
        pick     = 0;
        scanning = 1'b1;
        for (s = 1; s < SLOT_COUNT && scanning; s++) begin
            if (slot_state[s] == SLOT_EMPTY) begin
                scanning = 1'b0;
            end else begin
                if (slot_state[s] == SLOT_SLEEP && wake_at[s] < now)
                    slot_state[s] = SLOT_READY;
                if (slot_state[s] == SLOT_READY) begin
                    pick     = s;
                    scanning = 1'b0;
                end
            end
        end
        running = t_slot'(pick);
        return SEL_W'(pick);
    endfunction

    // update the shadow table for one request and return its answer
    function automatic t_answer apply_request(input t_cmd cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [DUR_W-1:0] dur,
                                              input logic [TIME_W-1:0] now);
        t_answer ans;
        int      s;
        t_slot   cur;
        ans.slot = '0;
        ans.full = 1'b0;
        cur      = running;
        case (cmd)
            CMD_REGISTER: begin
                // same key wins, else the first empty slot
                s = 1;
                while (s < SLOT_COUNT && slot_state[s] != SLOT_EMPTY && slot_key[s] != key)
                    s++;
                if (s < SLOT_COUNT) begin
                    slot_state[s] = SLOT_READY;
                    slot_key[s]   = key;
                    ans.slot      = SEL_W'(s);
                end else begin
                    ans.full = 1'b1;
                end
            end
            CMD_SLEEP: begin
                if (cur != IDLE_SLOT && slot_state[cur] != SLOT_EMPTY) begin
                    slot_state[cur] = SLOT_SLEEP;
                    wake_at[cur]    = now + {1'b0, dur};
                end
                ans.slot = run_next(now);
            end
            CMD_YIELD: begin
                ans.slot = run_next(now);
            end
            default: begin
                if (cur != IDLE_SLOT)
                    slot_state[cur] = SLOT_EXIT;
                ans.slot = run_next(now);
            end
        endcase
        return ans;
    endfunction

    // compare responses first, then record the new request of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_state[s] = SLOT_EMPTY;
                slot_key[s]   = '0;
                wake_at[s]    = '0;
            end
            running = IDLE_SLOT;
            answer_q.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: response with no request waiting (slot %0d full %0d)",
                             $time, i_rsp.selected_slot, i_rsp.table_full);
                    mismatch_count++;
                end else begin
                    want = answer_q.pop_front();
                    checked_count++;
                    if (i_rsp.table_full)
                        full_count++;
                    if (i_rsp.selected_slot !== want.slot) begin
                        $display("%0t: selected_slot expected %0d actual %0d",
                                 $time, want.slot, i_rsp.selected_slot);
                        mismatch_count++;
                    end
                    if (i_rsp.table_full !== want.full) begin
                        $display("%0t: table_full expected %0d actual %0d",
                                 $time, want.full, i_rsp.table_full);
                        mismatch_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                answer_q.push_back(apply_request(i_req.command, i_req.thread_key,
                                                 i_req.duration_ms, i_req.now_ms));
            o_pending <= answer_q.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the scheduler with a directed sequence (idle cases, sleep timing,
// exit, key reuse, table full) and then random requests over a full table,
// with random gaps on both sides; the checker module does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import pts_pkg::*;

    logic i_clk;
    logic i_rst_n;

    pts_req_if req_ch ();
    pts_rsp_if rsp_ch ();

    int errors;
    int pending;
    int checked;
    int full_seen;

    int                sent_by_cmd [4];
    logic              steady;
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0]  known_keys [SLOT_COUNT];

    priority_thread_scheduler_with_sleep_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pts_sched_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // response side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
        end
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one request, with random gaps ahead of it
    task automatic post_request(input t_cmd cmd, input logic [KEY_W-1:0] key,
                                input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
        while (!steady && $urandom_range(99) < 36) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.thread_key  <= key;
        req_ch.duration_ms <= dur;
        req_ch.now_ms      <= now;
        sent_by_cmd[int'(cmd)]++;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [DUR_W-1:0]  dur;
        int                r;

        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_YIELD;
        req_ch.thread_key  = '0;
        req_ch.duration_ms = '0;
        req_ch.now_ms      = '0;
        steady             = 1'b0;
        clock_ms           = '0;
        for (int i = 0; i < 4; i++)
            sent_by_cmd[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle thread cases on an empty table
        post_request(CMD_YIELD, 16'h0000, 31'd0, 32'd0);
        post_request(CMD_SLEEP, 16'h0000, 31'd10, 32'd0);
        post_request(CMD_EXIT, 16'h0000, 31'd0, 32'd0);
        // two threads, key extremes
        post_request(CMD_REGISTER, 16'h0000, 31'd0, 32'd0);
        post_request(CMD_REGISTER, 16'hFFFF, 31'd0, 32'd0);
        known_keys[1] = 16'h0000;
        known_keys[2] = 16'hFFFF;
        // sleep timing: wake only once now is strictly past the wake time
        post_request(CMD_YIELD, 16'h0000, 31'd0, 32'd100);
        post_request(CMD_SLEEP, 16'h0000, 31'd50, 32'd100);
        post_request(CMD_YIELD, 16'h0000, 31'd0, 32'd150);
        post_request(CMD_YIELD, 16'h0000, 31'd0, 32'd151);
        post_request(CMD_EXIT, 16'h0000, 31'd0, 32'd151);
        // longest sleep at the top of the timer wraps the wake time
        post_request(CMD_SLEEP, 16'h0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        post_request(CMD_EXIT, 16'h0000, 31'd0, 32'hFFFF_FFFF);
        // key reuse brings back an exited slot
        post_request(CMD_REGISTER, 16'h0000, 31'd0, 32'd160);
        // fill the rest of the table, then overflow it
        for (int s = 3; s < SLOT_COUNT; s++) begin
            known_keys[s] = KEY_W'(16'h1000 + s);
            post_request(CMD_REGISTER, known_keys[s], 31'd0, 32'd170);
        end
        post_request(CMD_REGISTER, 16'hBEEF, 31'd0, 32'd180);

        // random requests over the full table
        clock_ms = 32'd200;
        for (int n = 0; n < 750; n++) begin
            steady <= (n >= 250 && n < 400);
            if (n == 520)
                drain_responses();
            if ($urandom_range(19) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(40);
            if ($urandom_range(19) == 0)
                dur = DUR_W'($urandom());
            else
                dur = DUR_W'($urandom_range(120));
            if ($urandom_range(9) < 7)
                key = known_keys[$urandom_range(SLOT_COUNT - 1, 1)];
            else
                key = KEY_W'($urandom());
            r = $urandom_range(99);
            if (r < 25)
                cmd = CMD_REGISTER;
            else if (r < 55)
                cmd = CMD_SLEEP;
            else if (r < 80)
                cmd = CMD_YIELD;
            else
                cmd = CMD_EXIT;
            post_request(cmd, key, dur, clock_ms);
        end

        drain_responses();
        repeat (25) @(posedge i_clk);

        $display("covered %0d register, %0d sleep, %0d yield and %0d exit requests",
                 sent_by_cmd[int'(CMD_REGISTER)], sent_by_cmd[int'(CMD_SLEEP)],
                 sent_by_cmd[int'(CMD_YIELD)], sent_by_cmd[int'(CMD_EXIT)]);
        $display("%0d responses compared, %0d of them with the table full",
                 checked, full_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
